[design/tnf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet filter package
// Protocol codes, register indexes and the result record that passes from the
// byte parser to the output stage.
// ----------------------------------------------------------------------------
package tnf_pkg;

  // Telnet command bytes.
  localparam logic [7:0] IAC_CODE  = 8'hFF;
  localparam logic [7:0] SB_CODE   = 8'hFA;
  localparam logic [7:0] SE_CODE   = 8'hF0;
  localparam logic [7:0] WILL_CODE = 8'hFB;
  localparam logic [7:0] WONT_CODE = 8'hFC;
  localparam logic [7:0] DO_CODE   = 8'hFD;
  localparam logic [7:0] DONT_CODE = 8'hFE;

  // Received verb, held as its offset from WILL.
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ACCEPT_A = 1'b0;
  localparam logic CFG_ACCEPT_B = 1'b1;

  // Work produced by one received byte: nothing, one data byte, or a
  // three-byte reply (IAC, verb, option).
  typedef struct packed {
    logic       valid;
    logic       reply;
    logic [7:0] data;
    logic [7:0] verb;
  } tnf_job_t;

endpackage : tnf_pkg
`default_nettype wire

[design/tnf_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet byte parser
// Holds the parse mode and pending verb, and classifies each received byte
// into the output work it causes.
// ----------------------------------------------------------------------------
module tnf_parser
  import tnf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] accept_a,
  input  wire logic [7:0] accept_b,
  output tnf_job_t        job
);

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_IAC     = 3'd1,
    MODE_SUB     = 3'd2,
    MODE_SUB_IAC = 3'd3,
    MODE_OPTION  = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] verb_r, verb_nxt;
  logic       opt_ok;

  assign opt_ok = (rx_byte == accept_a) || (rx_byte == accept_b);

  // Next parse state and the work caused by the current byte.
  always_comb begin
    mode_nxt  = mode_r;
    verb_nxt  = verb_r;
    job.valid = 1'b0;
    job.reply = 1'b0;
    job.data  = rx_byte;
    job.verb  = DONT_CODE;
    case (mode_r)
      MODE_IAC: begin
        mode_nxt = MODE_NORMAL;
        if (rx_byte == IAC_CODE) begin
          // Escaped 0xFF passes as data.
          job.valid = 1'b1;
        end else if (rx_byte == SB_CODE) begin
          mode_nxt = MODE_SUB;
        end else if (rx_byte inside {[WILL_CODE:DONT_CODE]}) begin
          verb_nxt = rx_byte[1:0] - WILL_CODE[1:0];
          mode_nxt = MODE_OPTION;
        end
      end
      MODE_SUB: begin
        if (rx_byte == IAC_CODE) begin
          mode_nxt = MODE_SUB_IAC;
        end
      end
      MODE_SUB_IAC: begin
        // A doubled IAC keeps us waiting for SE.
        if (rx_byte == SE_CODE) begin
          mode_nxt = MODE_NORMAL;
        end else if (rx_byte != IAC_CODE) begin
          mode_nxt = MODE_SUB;
        end
      end
      MODE_OPTION: begin
        mode_nxt = MODE_NORMAL;
        case (verb_r)
          VERB_WILL: begin
            job.valid = 1'b1;
            job.reply = 1'b1;
            job.verb  = opt_ok ? DO_CODE : DONT_CODE;
          end
          VERB_DO: begin
            job.valid = 1'b1;
            job.reply = 1'b1;
            job.verb  = opt_ok ? WILL_CODE : WONT_CODE;
          end
          default: begin
            // WONT and DONT are swallowed.
            job.valid = 1'b0;
          end
        endcase
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (rx_byte == IAC_CODE) begin
          mode_nxt = MODE_IAC;
        end else begin
          job.valid = 1'b1;
        end
      end
    endcase
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      verb_r <= VERB_WILL;
    end else if (take) begin
      mode_r <= mode_nxt;
      verb_r <= verb_nxt;
    end
  end

endmodule : tnf_parser
`default_nettype wire

[design/telnet_iac_filter_negotiator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet IAC filter and option negotiator
// Splits a received telnet byte stream into data bytes and negotiation
// replies.
// ----------------------------------------------------------------------------
// At most one received byte is taken per cycle. A data byte is presented in
// the cycle after it is taken, and the next byte is taken in the cycle it
// leaves, so plain data flows at one byte per clock while out_stall is low.
// A WILL or DO option byte produces a three-byte reply (IAC, verb, option)
// that holds the output register until its final byte leaves, and input is
// stalled until then. Bytes that produce nothing (commands, subnegotiation
// content) are taken whenever the output register is free or delivering its
// final byte. The result register is the only thing between the two sides,
// and out_last marks the final byte caused by each received byte.
// ----------------------------------------------------------------------------
module telnet_iac_filter_negotiator
  import tnf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration writes
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // Received bytes
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  // Filtered data and replies
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_dest,
  output logic            out_last
);

  logic [7:0] accept_a_r;
  logic [7:0] accept_b_r;
  tnf_job_t   new_job;
  tnf_job_t   job_r;
  logic [1:0] idx_r;
  logic       in_take;
  logic       out_take;
  logic       out_done;

  // Accepted option registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_a_r <= 8'd1;
      accept_b_r <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEPT_A: accept_a_r <= cfg_wdata;
        CFG_ACCEPT_B: accept_b_r <= cfg_wdata;
        default: begin
          accept_a_r <= accept_a_r;
        end
      endcase
    end
  end

  // Handshake: a new byte is taken when the result register is empty or
  // hands over its final byte in this cycle.
  assign out_take = out_valid && !out_stall;
  assign out_done = out_take && out_last;
  assign in_stall = job_r.valid && !out_done;
  assign in_take  = in_valid && !in_stall;

  tnf_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .rx_byte  (in_byte),
    .accept_a (accept_a_r),
    .accept_b (accept_b_r),
    .job      (new_job)
  );

  // Result register and reply byte counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
      idx_r <= 2'd0;
    end else if (in_take) begin
      job_r <= new_job;
      idx_r <= 2'd0;
    end else if (out_done) begin
      job_r.valid <= 1'b0;
    end else if (out_take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Output byte selection.
  assign out_valid = job_r.valid;
  assign out_dest  = job_r.reply;
  assign out_last  = !job_r.reply || (idx_r == 2'd2);

  always_comb begin
    if (!job_r.reply) begin
      out_byte = job_r.data;
    end else begin
      case (idx_r)
        2'd0:    out_byte = IAC_CODE;
        2'd1:    out_byte = job_r.verb;
        default: out_byte = job_r.data;
      endcase
    end
  end

endmodule : telnet_iac_filter_negotiator
`default_nettype wire

[design/tnf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet filter port checker
// Watches the ports of the filter and flags handshake and sequencing errors.
// ----------------------------------------------------------------------------
module tnf_checker
  import tnf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_dest,
  input wire logic       out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_dest)
      && $stable(out_last))
    else $error("stalled result changed");

  // Data bytes are always single-byte runs.
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dest |-> out_last)
    else $error("data byte not marked last");

  // A reply run carries on without a gap until its final byte.
  a_reply_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_dest && !out_last |=> out_valid && out_dest)
    else $error("reply run broken");

  // Input waits while a result is held back.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

endmodule : tnf_checker

bind telnet_iac_filter_negotiator tnf_checker u_tnf_checker (.*);
`default_nettype wire
